// File: design/lsb_stego_payload_extract_macros.svh
// assertion macros for the lsb steganography extractor
`ifndef LSB_STEGO_PAYLOAD_EXTRACT_MACROS_SVH
`define LSB_STEGO_PAYLOAD_EXTRACT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define LSBX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define LSBX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/lsbx_pkg.sv
// types and constants shared by the lsb steganography extractor
`default_nettype none

package lsbx_pkg;

    typedef enum logic [1:0] {
        PH_NAME = 2'd0,
        PH_SIZE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        PL_RED   = 2'd0,
        PL_GREEN = 2'd1,
        PL_BLUE  = 2'd2
    } t_plane;

    typedef enum logic [2:0] {
        K_NAME     = 3'd0,
        K_NAME_END = 3'd1,
        K_SIZE     = 3'd2,
        K_DATA     = 3'd3,
        K_ERROR    = 3'd4
    } t_kind;

    localparam logic [5:0] BYTE_BITS = 6'd8;
    localparam logic [5:0] WORD_BITS = 6'd32;

    typedef struct packed {
        t_phase      phase;
        t_plane      plane;
        logic [5:0]  bit_count;
        logic [31:0] shift_value;
        logic [31:0] bytes_left;
    } t_dec_state;

    typedef struct packed {
        logic        valid;
        t_kind       kind;
        logic [31:0] value;
        logic        last;
    } t_result;

    localparam t_dec_state C_STATE_RESET = '{
        phase:       PH_NAME,
        plane:       PL_RED,
        bit_count:   6'd0,
        shift_value: 32'd0,
        bytes_left:  32'd0
    };

endpackage

`default_nettype wire

// File: design/lsbx_decode.sv
// next-state and result logic for one pixel of the extractor
`default_nettype none

module lsbx_decode
    import lsbx_pkg::*;
#(
    parameter int NAME_MAX = 128,
    localparam int NC_W = $clog2(NAME_MAX + 1)
) (
    input  t_dec_state        i_state,
    input  logic [NC_W-1:0]   i_name_count,
    input  logic [23:0]       i_pixel_rgb,
    input  logic              i_start_req,
    output t_dec_state        o_state,
    output logic [NC_W-1:0]   o_name_count,
    output t_result           o_result
);

    t_dec_state      cur;
    t_dec_state      nxt;
    logic [NC_W-1:0] nc_cur;
    logic [NC_W-1:0] nc_nxt;
    t_result         res;
    t_plane          plane_nxt;
    logic            take_b;
    logic [31:0]     shifted;
    logic [5:0]      cnt;

    always_comb begin
        cur    = i_start_req ? C_STATE_RESET : i_state;
        nc_cur = i_start_req ? '0 : i_name_count;
        nxt    = cur;
        nc_nxt = nc_cur;
        res    = '{valid: 1'b0, kind: K_NAME, value: 32'd0, last: 1'b0};

        // plane rotation, the unused code behaves as red
        case (cur.plane)
            PL_GREEN: begin
                take_b    = i_pixel_rgb[8];
                plane_nxt = PL_BLUE;
            end
            PL_BLUE: begin
                take_b    = i_pixel_rgb[0];
                plane_nxt = PL_RED;
            end
            default: begin
                take_b    = i_pixel_rgb[16];
                plane_nxt = PL_GREEN;
            end
        endcase

        shifted = {cur.shift_value[30:0], take_b};
        cnt     = cur.bit_count + 6'd1;

        if (cur.phase != PH_STOP) begin
            nxt.plane       = plane_nxt;
            nxt.shift_value = shifted;
            nxt.bit_count   = cnt;
            case (cur.phase)
                PH_NAME: begin
                    if (cnt >= BYTE_BITS) begin
                        nxt.shift_value = 32'd0;
                        nxt.bit_count   = 6'd0;
                        res.valid       = 1'b1;
                        if (shifted[7:0] == 8'd0) begin
                            nxt.phase = PH_SIZE;
                            res.kind  = K_NAME_END;
                        end else if (nc_cur >= NC_W'(NAME_MAX)) begin
                            nxt.phase = PH_STOP;
                            res.kind  = K_ERROR;
                            res.last  = 1'b1;
                        end else begin
                            nc_nxt    = nc_cur + NC_W'(1);
                            res.kind  = K_NAME;
                            res.value = {24'd0, shifted[7:0]};
                        end
                    end
                end
                PH_SIZE: begin
                    if (cnt >= WORD_BITS) begin
                        nxt.shift_value = 32'd0;
                        nxt.bit_count   = 6'd0;
                        res.valid       = 1'b1;
                        res.kind        = K_SIZE;
                        res.value       = shifted;
                        if (shifted == 32'd0) begin
                            nxt.phase = PH_STOP;
                            res.last  = 1'b1;
                        end else begin
                            nxt.phase      = PH_DATA;
                            nxt.bytes_left = shifted;
                        end
                    end
                end
                default: begin
                    if (cnt >= BYTE_BITS) begin
                        nxt.shift_value = 32'd0;
                        nxt.bit_count   = 6'd0;
                        if (cur.bytes_left != 32'd0) begin
                            nxt.bytes_left = cur.bytes_left - 32'd1;
                        end
                        res.valid = 1'b1;
                        res.kind  = K_DATA;
                        res.value = {24'd0, shifted[7:0]};
                        if (nxt.bytes_left == 32'd0) begin
                            nxt.phase = PH_STOP;
                            res.last  = 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_state      = nxt;
    assign o_name_count = nc_nxt;
    assign o_result     = res;

endmodule

`default_nettype wire

// File: design/lsb_stego_payload_extract.sv
// top level of the lsb steganography payload extractor
`default_nettype none

// Pulls one hidden bit out of each pixel, taking the least significant bit of
// red, green and blue in turn, most significant bit first. The stream decodes
// as a zero-terminated file name (one name-byte transaction per byte, then a
// name-end transaction), a 32-bit file size, and that many payload bytes, the
// final one flagged with last; a size of zero ends the stream, with last on the
// size transaction. A name longer than NAME_MAX bytes gives an error
// transaction with last set. After last the block swallows pixels with no
// result until a pixel arrives with start_req set, which restarts decoding on
// that pixel. One pixel is taken every cycle while o_in_stall is low; a pixel
// lands in the input register, the decode logic works from that register and
// the decoder state, and the result lands in the output register. The output
// register moves on as soon as it is taken, so stall on the result side reaches
// the pixel side only when both registers are full.

module lsb_stego_payload_extract
    import lsbx_pkg::*;
#(
    parameter int NAME_MAX = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [23:0] i_pixel_rgb,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_kind,
    output logic [31:0] o_value,
    output logic        o_last
);

`include "lsb_stego_payload_extract_macros.svh"

    localparam int NC_W = $clog2(NAME_MAX + 1);

    // input register
    logic            r_in_valid;
    logic [23:0]     r_pixel;
    logic            r_start;

    // decoder state
    t_dec_state      r_state;
    t_dec_state      n_state;
    logic [NC_W-1:0] r_name_count;
    logic [NC_W-1:0] n_name_count;

    // result register
    logic            r_out_valid;
    t_kind           r_kind;
    logic [31:0]     r_value;
    logic            r_last;

    t_result         dec_result;
    logic            out_free;
    logic            advance;
    logic            in_load;

    // the output register can take a new value when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    // the pixel in the input register is decoded whenever its result can land
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_load    = i_in_valid && !o_in_stall;

    lsbx_decode #(
        .NAME_MAX (NAME_MAX)
    ) u_decode (
        .i_state      (r_state),
        .i_name_count (r_name_count),
        .i_pixel_rgb  (r_pixel),
        .i_start_req  (r_start),
        .o_state      (n_state),
        .o_name_count (n_name_count),
        .o_result     (dec_result)
    );

    // input register, refilled in the same cycle it is drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_load) begin
            r_pixel <= i_pixel_rgb;
            r_start <= i_start_req;
        end
    end

    // decoder state moves once per decoded pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= C_STATE_RESET;
            r_name_count <= '0;
        end else if (advance) begin
            r_state      <= n_state;
            r_name_count <= n_name_count;
        end
    end

    // result register, only pixels that finish a byte or word fill it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && dec_result.valid;
        end
        if (advance && dec_result.valid) begin
            r_kind  <= dec_result.kind;
            r_value <= dec_result.value;
            r_last  <= dec_result.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_kind;
    assign o_value     = r_value;
    assign o_last      = r_last;

    // checks
    `LSBX_ASSERT_NEXT(a_last_stops, i_clk, i_rst_n, advance && dec_result.valid && dec_result.last, r_state.phase == PH_STOP, "decoder not stopped after a last transaction")
    `LSBX_ASSERT_SAME(a_error_last, i_clk, i_rst_n, r_out_valid && (r_kind == K_ERROR), r_last && (r_value == 32'd0), "error transaction without last or with nonzero value")
    `LSBX_ASSERT_SAME(a_name_bound, i_clk, i_rst_n, 1'b1, r_name_count <= NC_W'(NAME_MAX), "name counter past its limit")
    `LSBX_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid && i_out_stall, "pixel side stalled with room to move")

endmodule

`default_nettype wire
